### rtl/tts_pkg.sv
// Shared types and constants for the tick-time to slot-index splitter.
// Used by tts_divider and time_to_slot_index_top. No dependencies.
package tts_pkg;

   // Field widths.
   localparam int unsigned TICK_W = 64;
   localparam int unsigned DUR_W  = 32;
   localparam int unsigned QUO_W  = 16;
   localparam int unsigned SF_W   = 16;
   localparam int unsigned FR_W   = 8;
   localparam int unsigned SL_W   = 16;
   localparam int unsigned FIS_W  = 8;
   localparam int unsigned SIF_W  = 16;
   localparam int unsigned CSR_IDX_W = 3;

   // Divider pipeline shape: quotient bits resolved per register stage.
   localparam int unsigned STEPS_PER_STAGE = 2;
   localparam int unsigned DIV_STAGES      = TICK_W / STEPS_PER_STAGE;

   // Highest superframe counter value; the counter wraps after it.
   localparam logic [SF_W-1:0] SUPERFRAME_COUNT_MAX = 16'hFFFF;

   // Register reset values.
   localparam logic [DUR_W-1:0] SUPERFRAME_TICKS_RST = 32'd400000;
   localparam logic [DUR_W-1:0] FRAME_TICKS_RST      = 32'd100000;
   localparam logic [DUR_W-1:0] SLOT_TICKS_RST       = 32'd1000;
   localparam logic [FIS_W-1:0] FRAMES_IN_SF_RST     = 8'd4;
   localparam logic [SIF_W-1:0] SLOTS_IN_FRAME_RST   = 16'd100;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUPERFRAME_TICKS     = 3'd0,
      CSR_FRAME_TICKS          = 3'd1,
      CSR_SLOT_TICKS           = 3'd2,
      CSR_FRAMES_IN_SUPERFRAME = 3'd3,
      CSR_SLOTS_IN_FRAME       = 3'd4
   } csr_index_type;

   // Side information that travels with a request through the dividers.
   typedef struct packed {
      logic            valid;
      logic            zero_time;
      logic [SF_W-1:0] sf;
      logic [FR_W-1:0] fr;
   } tts_tag_type;

   typedef struct packed {
      tts_tag_type       tag;
      logic [TICK_W-1:0] dividend;
   } tts_div_in_type;

   typedef struct packed {
      tts_tag_type       tag;
      logic [QUO_W-1:0]  quotient;
      logic [TICK_W-1:0] remainder;
   } tts_div_out_type;

endpackage

### rtl/tts_divider.sv
// Pipelined restoring divider: 64-bit dividend by 32-bit divisor, low quotient
// bits and full remainder. Depends on tts_pkg.
module tts_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  tts_pkg::tts_div_in_type        div_in,
   input  logic [tts_pkg::DUR_W-1:0]      divisor,
   output tts_pkg::tts_div_out_type       div_out
);

   localparam int unsigned LAST = tts_pkg::DIV_STAGES - 1;

   tts_pkg::tts_tag_type              tag_ff  [tts_pkg::DIV_STAGES];
   logic [tts_pkg::TICK_W-1:0]        dvd_ff  [tts_pkg::DIV_STAGES];
   logic [tts_pkg::DUR_W-1:0]         rem_ff  [tts_pkg::DIV_STAGES];
   logic [tts_pkg::QUO_W-1:0]         quo_ff  [tts_pkg::DIV_STAGES];

   tts_pkg::tts_tag_type              tag_src [tts_pkg::DIV_STAGES];
   logic [tts_pkg::TICK_W-1:0]        dvd_src [tts_pkg::DIV_STAGES];
   logic [tts_pkg::DUR_W-1:0]         rem_src [tts_pkg::DIV_STAGES];
   logic [tts_pkg::QUO_W-1:0]         quo_src [tts_pkg::DIV_STAGES];
   logic [tts_pkg::DUR_W-1:0]         rem_in  [tts_pkg::DIV_STAGES];
   logic [tts_pkg::QUO_W-1:0]         quo_in  [tts_pkg::DIV_STAGES];

   genvar g;
   generate
      for (g = 0; g < tts_pkg::DIV_STAGES; g++) begin : gen_stage
         localparam int unsigned BASE = g * tts_pkg::STEPS_PER_STAGE;

         logic [tts_pkg::DUR_W-1:0] rem_v;
         logic [tts_pkg::QUO_W-1:0] quo_v;
         logic [tts_pkg::DUR_W:0]   trial;

         // Stage sources: the first stage starts from the new request.
         if (g == 0) begin : gen_first
            assign tag_src[g] = div_in.tag;
            assign dvd_src[g] = div_in.dividend;
            assign rem_src[g] = '0;
            assign quo_src[g] = '0;
         end else begin : gen_next
            assign tag_src[g] = tag_ff[g-1];
            assign dvd_src[g] = dvd_ff[g-1];
            assign rem_src[g] = rem_ff[g-1];
            assign quo_src[g] = quo_ff[g-1];
         end

         // Resolve the next quotient bits, one compare and subtract each.
         always_comb begin
            rem_v = rem_src[g];
            quo_v = quo_src[g];
            trial = '0;
            for (int s = 0; s < tts_pkg::STEPS_PER_STAGE; s++) begin
               trial = {rem_v, dvd_src[g][tts_pkg::TICK_W - 1 - BASE - s]};
               if (trial >= {1'b0, divisor}) begin
                  rem_v = tts_pkg::DUR_W'(trial - {1'b0, divisor});
                  quo_v = {quo_v[tts_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  rem_v = trial[tts_pkg::DUR_W-1:0];
                  quo_v = {quo_v[tts_pkg::QUO_W-2:0], 1'b0};
               end
            end
            rem_in[g] = rem_v;
            quo_in[g] = quo_v;
         end

         // Stage register; only the valid bit needs a reset.
         always_ff @(posedge clock) begin
            if (reset) begin
               tag_ff[g].valid <= 1'b0;
            end else if (advance) begin
               tag_ff[g] <= tag_src[g];
               dvd_ff[g] <= dvd_src[g];
               rem_ff[g] <= rem_in[g];
               quo_ff[g] <= quo_in[g];
            end
         end
      end
   endgenerate

   // A zero divisor gives an all-ones quotient and passes the dividend on.
   always_comb begin
      div_out.tag = tag_ff[LAST];
      if (divisor == '0) begin
         div_out.quotient  = '1;
         div_out.remainder = dvd_ff[LAST];
      end else begin
         div_out.quotient  = quo_ff[LAST];
         div_out.remainder = {{(tts_pkg::TICK_W - tts_pkg::DUR_W){1'b0}}, rem_ff[LAST]};
      end
   end

   // A stalled pipeline keeps its valid bits.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> tag_ff[0].valid == $past(tag_ff[0].valid) &&
                   tag_ff[LAST].valid == $past(tag_ff[LAST].valid))
      else $error("divider valid bits moved during a stall");

   // A moving pipeline loads the incoming request into the first stage.
   a_load_first: assert property (@(posedge clock) disable iff (reset)
      advance |=> tag_ff[0].valid == $past(div_in.tag.valid))
      else $error("divider first stage did not load the request");

endmodule

### rtl/time_to_slot_index_top.sv
// Top level of the tick-time to slot-index splitter: registers, three chained
// dividers and the output register. Depends on tts_pkg and tts_divider.

// Splits a 64-bit tick time into superframe counter, frame number and slot
// number. One request is accepted per clock cycle while the pipeline moves,
// and each result passes through three 64-step restoring dividers (superframe,
// frame and slot durations) of 32 stages each, two quotient bits per stage,
// and one output register. The whole pipeline moves only when the output
// register is empty or being drained. A time exactly on a slot boundary
// belongs to the slot before it; time zero gives the last slot of the last
// superframe with rsp_zero_time_flag set. A zero duration divides as
// all-ones quotient with the dividend as remainder. Configuration writes are
// taken in any cycle but must only be issued while no request is in flight.
module time_to_slot_index_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tts_pkg::TICK_W-1:0]        req_now_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tts_pkg::SF_W-1:0]          rsp_superframe_index,
   output logic [tts_pkg::FR_W-1:0]          rsp_frame_index,
   output logic [tts_pkg::SL_W-1:0]          rsp_slot_index,
   output logic                              rsp_zero_time_flag,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tts_pkg::DUR_W-1:0]         csr_wdata
);

   logic [tts_pkg::DUR_W-1:0] superframe_ticks_ff;
   logic [tts_pkg::DUR_W-1:0] frame_ticks_ff;
   logic [tts_pkg::DUR_W-1:0] slot_ticks_ff;
   logic [tts_pkg::FIS_W-1:0] frames_in_sf_ff;
   logic [tts_pkg::SIF_W-1:0] slots_in_frame_ff;

   logic                      advance;
   tts_pkg::tts_div_in_type   sf_div_in, fr_div_in, sl_div_in;
   tts_pkg::tts_div_out_type  sf_div_out, fr_div_out, sl_div_out;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [tts_pkg::SF_W-1:0]  sf_ff, sf_in;
   logic [tts_pkg::FR_W-1:0]  fr_ff, fr_in;
   logic [tts_pkg::SL_W-1:0]  sl_ff, sl_in;
   logic                      zero_ff;

   logic [tts_pkg::SF_W-1:0]  sf_adj;
   logic [tts_pkg::FR_W-1:0]  fr_adj;
   logic [tts_pkg::SL_W-1:0]  sl_adj;

   // Configuration registers; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         superframe_ticks_ff <= tts_pkg::SUPERFRAME_TICKS_RST;
         frame_ticks_ff      <= tts_pkg::FRAME_TICKS_RST;
         slot_ticks_ff       <= tts_pkg::SLOT_TICKS_RST;
         frames_in_sf_ff     <= tts_pkg::FRAMES_IN_SF_RST;
         slots_in_frame_ff   <= tts_pkg::SLOTS_IN_FRAME_RST;
      end else if (csr_valid) begin
         unique case (tts_pkg::csr_index_type'(csr_index))
            tts_pkg::CSR_SUPERFRAME_TICKS: begin
               superframe_ticks_ff <= csr_wdata;
            end
            tts_pkg::CSR_FRAME_TICKS: begin
               frame_ticks_ff <= csr_wdata;
            end
            tts_pkg::CSR_SLOT_TICKS: begin
               slot_ticks_ff <= csr_wdata;
            end
            tts_pkg::CSR_FRAMES_IN_SUPERFRAME: begin
               frames_in_sf_ff <= csr_wdata[tts_pkg::FIS_W-1:0];
            end
            tts_pkg::CSR_SLOTS_IN_FRAME: begin
               slots_in_frame_ff <= csr_wdata[tts_pkg::SIF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline moves when the output register can take a result.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Superframe level. Reducing modulo 65536 superframes and keeping the low
   // 16 quotient bits is the same as one division by the superframe length.
   always_comb begin
      sf_div_in.tag.valid     = req_valid;
      sf_div_in.tag.zero_time = (req_now_ticks == '0);
      sf_div_in.tag.sf        = '0;
      sf_div_in.tag.fr        = '0;
      sf_div_in.dividend      = req_now_ticks;
   end

   tts_divider u_sf_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .div_in  (sf_div_in),
      .divisor (superframe_ticks_ff),
      .div_out (sf_div_out)
   );

   // Boundary borrow on the superframe counter, then the frame division.
   always_comb begin
      sf_adj = sf_div_out.quotient[tts_pkg::SF_W-1:0];
      if (sf_div_out.remainder == '0) begin
         sf_adj = (sf_adj != '0) ? sf_adj - 1'b1 : tts_pkg::SUPERFRAME_COUNT_MAX;
      end
      fr_div_in.tag      = sf_div_out.tag;
      fr_div_in.tag.sf   = sf_adj;
      fr_div_in.dividend = sf_div_out.remainder;
   end

   tts_divider u_fr_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .div_in  (fr_div_in),
      .divisor (frame_ticks_ff),
      .div_out (fr_div_out)
   );

   // Boundary borrow on the frame number, then the slot division.
   always_comb begin
      fr_adj = fr_div_out.quotient[tts_pkg::FR_W-1:0];
      if (fr_div_out.remainder == '0) begin
         fr_adj = (fr_adj != '0) ? fr_adj - 1'b1 : frames_in_sf_ff - 1'b1;
      end
      sl_div_in.tag      = fr_div_out.tag;
      sl_div_in.tag.fr   = fr_adj;
      sl_div_in.dividend = fr_div_out.remainder;
   end

   tts_divider u_sl_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .div_in  (sl_div_in),
      .divisor (slot_ticks_ff),
      .div_out (sl_div_out)
   );

   // Boundary borrow on the slot number; time zero overrides everything.
   always_comb begin
      sl_adj = sl_div_out.quotient[tts_pkg::SL_W-1:0];
      if (sl_div_out.remainder == '0) begin
         sl_adj = (sl_adj != '0) ? sl_adj - 1'b1 : slots_in_frame_ff - 1'b1;
      end
      rsp_valid_in = sl_div_out.tag.valid;
      if (sl_div_out.tag.zero_time) begin
         sf_in = tts_pkg::SUPERFRAME_COUNT_MAX;
         fr_in = frames_in_sf_ff - 1'b1;
         sl_in = slots_in_frame_ff - 1'b1;
      end else begin
         sf_in = sl_div_out.tag.sf;
         fr_in = sl_div_out.tag.fr;
         sl_in = sl_adj;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
         sf_ff        <= sf_in;
         fr_ff        <= fr_in;
         sl_ff        <= sl_in;
         zero_ff      <= sl_div_out.tag.zero_time;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_superframe_index = sf_ff;
   assign rsp_frame_index      = fr_ff;
   assign rsp_slot_index       = sl_ff;
   assign rsp_zero_time_flag   = zero_ff;

   // Time zero reports the last superframe.
   a_zero_sf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_time_flag |->
         rsp_superframe_index == tts_pkg::SUPERFRAME_COUNT_MAX)
      else $error("time zero did not give the last superframe");

   // Time zero reports the last frame and slot of the configured layout.
   a_zero_fr_sl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_time_flag |->
         rsp_frame_index == tts_pkg::FR_W'(frames_in_sf_ff - 1'b1) &&
         rsp_slot_index == tts_pkg::SL_W'(slots_in_frame_ff - 1'b1))
      else $error("time zero did not give the last frame and slot");

   // Intake only stops while a finished result waits.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request intake stalled without a waiting result");

endmodule
